// ----- rtl/core/masl_pkg.sv -----
// ----------------------------------------------------------------------------
// masl_pkg
// Shared types, codes and helper functions of the multi-actuator slew limiter.
// ----------------------------------------------------------------------------
package masl_pkg;

    typedef enum logic [2:0] {
        MODE_TICK          = 3'd0,
        MODE_FLAPS_DOWN    = 3'd1,
        MODE_FLAPS_UP      = 3'd2,
        MODE_BRAKE_EXTEND  = 3'd3,
        MODE_BRAKE_RETRACT = 3'd4
    } mode_e;

    typedef enum logic [2:0] {
        REG_MAX_FLAP        = 3'd0,
        REG_FLAP_SLEW       = 3'd1,
        REG_MAX_SPEED_BRAKE = 3'd2,
        REG_BRAKE_INCREMENT = 3'd3,
        REG_BRAKE_SLEW      = 3'd4,
        REG_GEAR_SLEW       = 3'd5,
        REG_FUEL_THRESHOLD  = 3'd6
    } reg_index_e;

    typedef struct packed {
        logic [15:0] max_flap;
        logic [15:0] flap_slew;
        logic [15:0] max_speed_brake;
        logic [15:0] brake_increment;
        logic [15:0] brake_slew;
        logic [15:0] gear_slew;
        logic [15:0] fuel_threshold;
    } cfg_t;

    typedef struct packed {
        logic step;
        logic tick;
        logic handle_down;
    } leg_ctrl_t;

    localparam logic [15:0] FLAP_NOTCH = 16'd2860;
    localparam logic [14:0] GEAR_DOWN  = 15'd25736;

    localparam logic [15:0] RST_MAX_FLAP        = 16'd8192;
    localparam logic [15:0] RST_FLAP_SLEW       = 16'd64;
    localparam logic [15:0] RST_MAX_SPEED_BRAKE = 16'd16384;
    localparam logic [15:0] RST_BRAKE_INCREMENT = 16'd2048;
    localparam logic [15:0] RST_BRAKE_SLEW      = 16'd64;
    localparam logic [15:0] RST_GEAR_SLEW       = 16'd64;
    localparam logic [15:0] RST_FUEL_THRESHOLD  = 16'd1000;

    function automatic logic [15:0] step_up(input logic [15:0] goal,
                                            input logic [15:0] incr,
                                            input logic [15:0] lim);
        logic [16:0] sum;
        sum = {1'b0, goal} + {1'b0, incr};
        step_up = (sum > {1'b0, lim}) ? lim : sum[15:0];
    endfunction

    function automatic logic [15:0] step_down(input logic [15:0] goal,
                                              input logic [15:0] decr);
        step_down = (goal > decr) ? goal - decr : 16'd0;
    endfunction

    function automatic logic [15:0] slew_step(input logic [15:0] now,
                                              input logic [15:0] goal,
                                              input logic [15:0] rate);
        logic [16:0] sum;
        logic [15:0] diff;
        sum  = {1'b0, now} + {1'b0, rate};
        diff = (now > rate) ? now - rate : 16'd0;
        if (goal > now) begin
            slew_step = (sum > {1'b0, goal}) ? goal : sum[15:0];
        end else if (goal < now) begin
            slew_step = (diff < goal) ? goal : diff;
        end else begin
            slew_step = now;
        end
    endfunction

endpackage

// ----- rtl/core/masl_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// masl_cfg_regs
// Configuration register file behind the APB port.
// ----------------------------------------------------------------------------
module masl_cfg_regs (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output masl_pkg::cfg_t      cfg
);
    import masl_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [2:0]  idx;
    logic [15:0] rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_flap        <= RST_MAX_FLAP;
            cfg_reg.flap_slew       <= RST_FLAP_SLEW;
            cfg_reg.max_speed_brake <= RST_MAX_SPEED_BRAKE;
            cfg_reg.brake_increment <= RST_BRAKE_INCREMENT;
            cfg_reg.brake_slew      <= RST_BRAKE_SLEW;
            cfg_reg.gear_slew       <= RST_GEAR_SLEW;
            cfg_reg.fuel_threshold  <= RST_FUEL_THRESHOLD;
        end else if (wr_en) begin
            unique case (idx)
                REG_MAX_FLAP:        cfg_reg.max_flap        <= pwdata[15:0];
                REG_FLAP_SLEW:       cfg_reg.flap_slew       <= pwdata[15:0];
                REG_MAX_SPEED_BRAKE: cfg_reg.max_speed_brake <= pwdata[15:0];
                REG_BRAKE_INCREMENT: cfg_reg.brake_increment <= pwdata[15:0];
                REG_BRAKE_SLEW:      cfg_reg.brake_slew      <= pwdata[15:0];
                REG_GEAR_SLEW:       cfg_reg.gear_slew       <= pwdata[15:0];
                REG_FUEL_THRESHOLD:  cfg_reg.fuel_threshold  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MAX_FLAP:        rd_val = cfg_reg.max_flap;
            REG_FLAP_SLEW:       rd_val = cfg_reg.flap_slew;
            REG_MAX_SPEED_BRAKE: rd_val = cfg_reg.max_speed_brake;
            REG_BRAKE_INCREMENT: rd_val = cfg_reg.brake_increment;
            REG_BRAKE_SLEW:      rd_val = cfg_reg.brake_slew;
            REG_GEAR_SLEW:       rd_val = cfg_reg.gear_slew;
            REG_FUEL_THRESHOLD:  rd_val = cfg_reg.fuel_threshold;
            default:             rd_val = 16'd0;
        endcase
    end

    assign prdata = {16'd0, rd_val};

endmodule

// ----- rtl/core/masl_gear_leg.sv -----
// ----------------------------------------------------------------------------
// masl_gear_leg
// One gear leg: angle and retracted flag, slewed toward down or up per tick.
// ----------------------------------------------------------------------------
module masl_gear_leg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  masl_pkg::leg_ctrl_t  ctrl,
    input  logic                 leg_ok,
    input  logic [15:0]          gear_slew,
    output logic [14:0]          angle_next,
    output logic                 up_next
);
    import masl_pkg::*;

    logic [14:0] angle_reg;
    logic        up_reg;
    logic [16:0] sum;

    assign sum = {2'b00, angle_reg} + {1'b0, gear_slew};

    always_comb begin
        angle_next = angle_reg;
        up_next    = up_reg;
        if (ctrl.tick && leg_ok) begin
            if (ctrl.handle_down) begin
                if (angle_reg != GEAR_DOWN) begin
                    angle_next = (sum > {2'b00, GEAR_DOWN}) ? GEAR_DOWN : sum[14:0];
                    up_next    = 1'b0;
                end
            end else if (angle_reg != 15'd0) begin
                if ({1'b0, angle_reg} > gear_slew) begin
                    angle_next = angle_reg - gear_slew[14:0];
                end else begin
                    angle_next = 15'd0;
                    up_next    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= 15'd0;
            up_reg    <= 1'b0;
        end else if (ctrl.step) begin
            angle_reg <= angle_next;
            up_reg    <= up_next;
        end
    end

endmodule

// ----- rtl/core/multi_actuator_slew_limiter.sv -----
// ----------------------------------------------------------------------------
// multi_actuator_slew_limiter
// Rate limiter for flaps, speed brake and gear legs.
//
// Input stream (s_*): one transaction per command or tick; s_tuser carries
// the mode. Each accepted transaction yields exactly one result transaction
// on m_* showing all targets, positions, leg angles and flags after it.
// Commands step the flap or speed brake target; a tick slews every healthy
// actuator and refreshes the status bits.
// m_tvalid rises once an accepted transaction has passed the input register,
// then the result register. Throughput: one transaction per cycle while
// m_tready stays high; the only loop is the state update between the two
// registers.
// When m_tready is low the result register holds and the input register
// still takes one more transaction; s_tready then drops until the result
// is taken.
// Reset (aresetn low, synchronous) clears all actuator state to zero, empties
// both registers and loads the configuration reset values. The user must write
// configuration over APB only while the stream is idle; it is not enforced.
// ----------------------------------------------------------------------------
module multi_actuator_slew_limiter #(
    parameter int LEG_COUNT     = 3,
    parameter int POSITION_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [0] flaps_ok, [1] speed_brake_ok, [4:2] leg_ok, [5] handle_down,
    // [6] wheel_brakes_on, [22:7] fuel_level, [23] zero
    input  logic [23:0]  s_tdata,
    // [2:0] mode
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] flap_target, [31:16] flap_angle, [47:32] brake_target,
    // [63:48] brake_position, [78:64] nose_leg, [93:79] right_leg,
    // [108:94] left_leg, [111:109] legs_up, [114:112] status_bits,
    // [119:115] zero
    output logic [119:0] m_tdata
);
    import masl_pkg::*;

    localparam int          POS_W     = (POSITION_BITS < 16) ? POSITION_BITS : 16;
    localparam logic [15:0] POS_LIMIT = 16'((32'd1 << POS_W) - 32'd1);

    cfg_t cfg;

    masl_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic              in_valid_reg;
    logic [23:0]       in_data_reg;
    logic [2:0]        in_mode_reg;
    logic              out_valid_reg;
    logic [119:0]      out_data_reg;
    logic              advance;
    logic              is_tick;

    logic [POS_W-1:0]  flap_goal_reg, flap_goal_next;
    logic [POS_W-1:0]  flap_now_reg, flap_now_next;
    logic [POS_W-1:0]  brake_goal_reg, brake_goal_next;
    logic [POS_W-1:0]  brake_now_reg, brake_now_next;
    logic [2:0]        status_reg, status_next;

    logic [15:0]       flap_lim, brake_lim;
    logic              flaps_ok, speed_brake_ok, handle_down, wheel_brakes_on;
    logic [2:0]        leg_ok;
    logic [15:0]       fuel_level;

    leg_ctrl_t         leg_ctrl;
    logic [14:0]       leg_angle_next [LEG_COUNT];
    logic [LEG_COUNT-1:0] leg_up_next;
    logic [14:0]       leg_out [3];
    logic [2:0]        legs_up_out;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_mode_reg <= s_tuser;
        end
    end

    assign flaps_ok        = in_data_reg[0];
    assign speed_brake_ok  = in_data_reg[1];
    assign leg_ok          = in_data_reg[4:2];
    assign handle_down     = in_data_reg[5];
    assign wheel_brakes_on = in_data_reg[6];
    assign fuel_level      = in_data_reg[22:7];

    assign is_tick   = (mode_e'(in_mode_reg) == MODE_TICK);
    assign flap_lim  = (cfg.max_flap > POS_LIMIT) ? POS_LIMIT : cfg.max_flap;
    assign brake_lim = (cfg.max_speed_brake > POS_LIMIT) ? POS_LIMIT : cfg.max_speed_brake;

    always_comb begin
        flap_goal_next  = flap_goal_reg;
        flap_now_next   = flap_now_reg;
        brake_goal_next = brake_goal_reg;
        brake_now_next  = brake_now_reg;
        status_next     = status_reg;
        unique case (mode_e'(in_mode_reg))
            MODE_TICK: begin
                if (flaps_ok) begin
                    flap_now_next = POS_W'(slew_step(16'(flap_now_reg), 16'(flap_goal_reg),
                                                     cfg.flap_slew));
                end
                if (speed_brake_ok) begin
                    brake_now_next = POS_W'(slew_step(16'(brake_now_reg),
                                                      16'(brake_goal_reg), cfg.brake_slew));
                end
                status_next = {brake_goal_reg == '0, !wheel_brakes_on,
                               fuel_level >= cfg.fuel_threshold};
            end
            MODE_FLAPS_DOWN: begin
                flap_goal_next = POS_W'(step_up(16'(flap_goal_reg), FLAP_NOTCH, flap_lim));
            end
            MODE_FLAPS_UP: begin
                flap_goal_next = POS_W'(step_down(16'(flap_goal_reg), FLAP_NOTCH));
            end
            MODE_BRAKE_EXTEND: begin
                brake_goal_next = POS_W'(step_up(16'(brake_goal_reg), cfg.brake_increment,
                                                 brake_lim));
            end
            MODE_BRAKE_RETRACT: begin
                brake_goal_next = POS_W'(step_down(16'(brake_goal_reg), cfg.brake_increment));
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flap_goal_reg  <= '0;
            flap_now_reg   <= '0;
            brake_goal_reg <= '0;
            brake_now_reg  <= '0;
            status_reg     <= 3'd0;
        end else if (advance) begin
            flap_goal_reg  <= flap_goal_next;
            flap_now_reg   <= flap_now_next;
            brake_goal_reg <= brake_goal_next;
            brake_now_reg  <= brake_now_next;
            status_reg     <= status_next;
        end
    end

    assign leg_ctrl.step        = advance;
    assign leg_ctrl.tick        = is_tick;
    assign leg_ctrl.handle_down = handle_down;

    for (genvar i = 0; i < LEG_COUNT; i++) begin : g_leg
        logic ok;
        if (i < 3) begin : g_ok
            assign ok = leg_ok[i];
        end else begin : g_no_ok
            assign ok = 1'b0;
        end
        masl_gear_leg u_leg (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (leg_ctrl),
            .leg_ok     (ok),
            .gear_slew  (cfg.gear_slew),
            .angle_next (leg_angle_next[i]),
            .up_next    (leg_up_next[i])
        );
    end

    for (genvar j = 0; j < 3; j++) begin : g_leg_out
        if (j < LEG_COUNT) begin : g_present
            assign leg_out[j]     = leg_angle_next[j];
            assign legs_up_out[j] = leg_up_next[j];
        end else begin : g_absent
            assign leg_out[j]     = 15'd0;
            assign legs_up_out[j] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {5'd0, status_next, legs_up_out, leg_out[2], leg_out[1],
                             leg_out[0], 16'(brake_now_next), 16'(brake_goal_next),
                             16'(flap_now_next), 16'(flap_goal_next)};
        end
    end

`ifndef SYNTHESIS
    a_advance_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("result register empty after a transaction advanced");

    a_stalled_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a stalled transaction");

    a_status_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_tick |=> $stable(status_reg))
        else $error("status bits changed on a command");

    a_flap_target_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[15:0] <= POS_LIMIT)
        else $error("flap target beyond position range");

    a_nose_leg_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> out_data_reg[78:64] <= GEAR_DOWN)
        else $error("nose leg beyond down position");
`endif

endmodule

// ----- tb/sv/multi_actuator_slew_limiter_test.sv -----
// ----------------------------------------------------------------------------
// multi_actuator_slew_limiter_test
// Self-checking bench for the flap, speed brake and gear leg slew limiter.
//
// Commands and ticks go in on the s_ stream. A local actuator model predicts
// the state report for every accepted transaction, and each report on the
// m_ stream is checked field by field against the oldest prediction.
// Configuration is written over APB between phases while the stream is
// idle: reset values, all-ones and all-zero extremes, a fixed set, then random sets.
// Both stream sides idle at random. One phase holds the result side off
// long enough to fill the block and stall the input.
// ----------------------------------------------------------------------------
module multi_actuator_slew_limiter_test;
    import masl_pkg::*;

    localparam int          CYCLE_LIMIT       = 1000000;
    localparam int          PIPE_LATENCY      = 2;
    localparam int          REG_COUNT         = 7;
    localparam logic [2:0]  MODE_FIRST_UNUSED = 3'd5;
    localparam logic [2:0]  MODE_MID_UNUSED   = 3'd6;
    localparam logic [2:0]  MODE_LAST_UNUSED  = 3'd7;
    localparam logic [15:0] ALL_ONES          = 16'hFFFF;

    typedef struct packed {
        logic [15:0] fuel_level;
        logic        wheel_brakes_on;
        logic        handle_down;
        logic [2:0]  leg_ok;
        logic        speed_brake_ok;
        logic        flaps_ok;
    } cmd_fields_t;

    typedef struct packed {
        logic [4:0]  fill;
        logic [2:0]  status_bits;
        logic [2:0]  legs_up;
        logic [14:0] left_leg;
        logic [14:0] right_leg;
        logic [14:0] nose_leg;
        logic [15:0] brake_position;
        logic [15:0] brake_target;
        logic [15:0] flap_angle;
        logic [15:0] flap_target;
    } report_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [4:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = MODE_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;

    // model state
    logic [15:0] reg_shadow [REG_COUNT];
    logic [15:0] flap_goal;
    logic [15:0] flap_pos;
    logic [15:0] brake_goal;
    logic [15:0] brake_pos;
    logic [14:0] leg_pos [3];
    logic [2:0]  legs_up_now;
    logic [2:0]  status_now;

    report_t     expected_reports [$];
    int unsigned failures     = 0;
    int unsigned cycle_count  = 0;
    int unsigned s_gap_pct    = 0;
    int unsigned m_stall_pct  = 0;
    int unsigned hold_request = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    logic        handle_setting = 1'b0;

    multi_actuator_slew_limiter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // actuator model
    // ------------------------------------------------------------------
    task automatic reset_model();
        reg_shadow[REG_MAX_FLAP]        = RST_MAX_FLAP;
        reg_shadow[REG_FLAP_SLEW]       = RST_FLAP_SLEW;
        reg_shadow[REG_MAX_SPEED_BRAKE] = RST_MAX_SPEED_BRAKE;
        reg_shadow[REG_BRAKE_INCREMENT] = RST_BRAKE_INCREMENT;
        reg_shadow[REG_BRAKE_SLEW]      = RST_BRAKE_SLEW;
        reg_shadow[REG_GEAR_SLEW]       = RST_GEAR_SLEW;
        reg_shadow[REG_FUEL_THRESHOLD]  = RST_FUEL_THRESHOLD;
        flap_goal   = '0;
        flap_pos    = '0;
        brake_goal  = '0;
        brake_pos   = '0;
        leg_pos     = '{default: '0};
        legs_up_now = '0;
        status_now  = '0;
    endtask

    function automatic logic [15:0] raise_target(logic [15:0] goal, logic [15:0] amount,
                                                 logic [15:0] ceiling);
        int unsigned total;
        total = goal + amount;
        return (total > ceiling) ? ceiling : total[15:0];
    endfunction

    function automatic logic [15:0] lower_target(logic [15:0] goal, logic [15:0] amount);
        return (goal > amount) ? goal - amount : 16'd0;
    endfunction

    function automatic logic [15:0] move_toward(logic [15:0] pos, logic [15:0] goal,
                                                logic [15:0] rate);
        int p;
        int g;
        int r;
        p = pos;
        g = goal;
        r = rate;
        if (g > p)
            return (p + r > g) ? goal : 16'(p + r);
        if (g < p)
            return (p - r < g) ? goal : 16'(p - r);
        return pos;
    endfunction

    function automatic void slew_actuators(cmd_fields_t f);
        int          a;
        int          gear;
        int          i;
        logic [2:0]  st;
        gear = reg_shadow[REG_GEAR_SLEW];
        if (f.flaps_ok)
            flap_pos = move_toward(flap_pos, flap_goal, reg_shadow[REG_FLAP_SLEW]);
        if (f.speed_brake_ok)
            brake_pos = move_toward(brake_pos, brake_goal, reg_shadow[REG_BRAKE_SLEW]);
        for (i = 0; i < 3; i++) begin
            if (f.leg_ok[i]) begin
                a = leg_pos[i];
                if (f.handle_down) begin
                    if (a != GEAR_DOWN) begin
                        a = a + gear;
                        if (a > GEAR_DOWN)
                            a = GEAR_DOWN;
                        legs_up_now[i] = 1'b0;
                    end
                end else if (a != 0) begin
                    if (a > gear) begin
                        a = a - gear;
                    end else begin
                        a = 0;
                        legs_up_now[i] = 1'b1;
                    end
                end
                leg_pos[i] = a[14:0];
            end
        end
        st[0] = f.fuel_level >= reg_shadow[REG_FUEL_THRESHOLD];
        st[1] = !f.wheel_brakes_on;
        st[2] = brake_goal == 16'd0;
        status_now = st;
    endfunction

    function automatic report_t advance_actuators(logic [2:0] mode, cmd_fields_t f);
        report_t r;
        case (mode)
            MODE_TICK:          slew_actuators(f);
            MODE_FLAPS_DOWN:    flap_goal = raise_target(flap_goal, FLAP_NOTCH,
                                                         reg_shadow[REG_MAX_FLAP]);
            MODE_FLAPS_UP:      flap_goal = lower_target(flap_goal, FLAP_NOTCH);
            MODE_BRAKE_EXTEND:  brake_goal = raise_target(brake_goal,
                                                          reg_shadow[REG_BRAKE_INCREMENT],
                                                          reg_shadow[REG_MAX_SPEED_BRAKE]);
            MODE_BRAKE_RETRACT: brake_goal = lower_target(brake_goal,
                                                          reg_shadow[REG_BRAKE_INCREMENT]);
            default: ;
        endcase
        r.fill           = '0;
        r.flap_target    = flap_goal;
        r.flap_angle     = flap_pos;
        r.brake_target   = brake_goal;
        r.brake_position = brake_pos;
        r.nose_leg       = leg_pos[0];
        r.right_leg      = leg_pos[1];
        r.left_leg       = leg_pos[2];
        r.legs_up        = legs_up_now;
        r.status_bits    = status_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic cmd_fields_t make_fields(logic flaps_ok, logic speed_brake_ok,
                                                logic [2:0] leg_ok, logic handle_down,
                                                logic wheel_brakes_on, logic [15:0] fuel);
        cmd_fields_t f;
        f.flaps_ok        = flaps_ok;
        f.speed_brake_ok  = speed_brake_ok;
        f.leg_ok          = leg_ok;
        f.handle_down     = handle_down;
        f.wheel_brakes_on = wheel_brakes_on;
        f.fuel_level      = fuel;
        return f;
    endfunction

    function automatic cmd_fields_t random_fields();
        return make_fields(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    endfunction

    // mostly healthy systems with a handle that stays put for a while
    function automatic cmd_fields_t flight_fields();
        cmd_fields_t f;
        f = random_fields();
        if ($urandom_range(0, 9) == 0)
            return f;
        if ($urandom_range(0, 9) != 0)
            f.flaps_ok = 1'b1;
        if ($urandom_range(0, 9) != 0)
            f.speed_brake_ok = 1'b1;
        if ($urandom_range(0, 3) != 0)
            f.leg_ok = 3'b111;
        if ($urandom_range(0, 14) == 0)
            handle_setting = !handle_setting;
        f.handle_down = handle_setting;
        if ($urandom_range(0, 3) == 0)
            f.fuel_level = 16'(reg_shadow[REG_FUEL_THRESHOLD] + $urandom_range(0, 2) - 1);
        return f;
    endfunction

    function automatic logic [2:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return MODE_TICK;
        if (r < 56)
            return MODE_FLAPS_DOWN;
        if (r < 67)
            return MODE_FLAPS_UP;
        if (r < 79)
            return MODE_BRAKE_EXTEND;
        if (r < 96)
            return MODE_BRAKE_RETRACT;
        return 3'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
    endfunction

    function automatic logic [15:0] pick_reg(int unsigned lo, int unsigned hi);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return ALL_ONES;
        return 16'($urandom_range(lo, hi));
    endfunction

    function automatic logic [15:0] pick_gear_slew();
        case ($urandom_range(0, 5))
            0:       return 16'(GEAR_DOWN / 2);
            1:       return 16'(GEAR_DOWN / 4);
            2:       return 16'(GEAR_DOWN / 8);
            default: return pick_reg(200, 13000);
        endcase
    endfunction

    task automatic write_reg(input reg_index_e idx, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        reg_shadow[idx] = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_all_regs(input logic [15:0] value);
        int i;
        for (i = 0; i < REG_COUNT; i++)
            write_reg(reg_index_e'(i), value);
    endtask

    // offer one transaction, predict its report once taken, then idle if gap is nonzero
    task automatic send_item(input logic [2:0] mode, input cmd_fields_t f,
                             input int unsigned gap);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, f};
        s_tuser  <= mode;
        do @(posedge aclk); while (!s_tready);
        expected_reports.push_back(advance_actuators(mode, f));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_reports();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 1) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_commands();
        int i;
        send_item(MODE_TICK, make_fields(1'b0, 1'b0, 3'b000, 1'b0, 1'b1, 16'd0), 0);
        for (i = 0; i < 4; i++)
            send_item(MODE_FLAPS_DOWN, random_fields(), 0);
        send_item(MODE_BRAKE_EXTEND, random_fields(), 1);
        send_item(MODE_BRAKE_EXTEND, random_fields(), 0);
        send_item(MODE_TICK,
                  make_fields(1'b1, 1'b1, 3'b101, 1'b1, 1'b0, RST_FUEL_THRESHOLD), 0);
        for (i = 0; i < 4; i++)
            send_item(MODE_FLAPS_UP, random_fields(), 0);
        for (i = 0; i < 3; i++)
            send_item(MODE_BRAKE_RETRACT, random_fields(), 0);
        send_item(MODE_FIRST_UNUSED, make_fields(1'b1, 1'b1, 3'b111, 1'b1, 1'b1, ALL_ONES), 0);
        send_item(MODE_MID_UNUSED, random_fields(), 2);
        send_item(MODE_LAST_UNUSED, random_fields(), 0);
        wait_for_reports();
    endtask

    task automatic test_config_extremes();
        write_all_regs(ALL_ONES);
        send_item(MODE_BRAKE_EXTEND, random_fields(), 0);
        send_item(MODE_FLAPS_DOWN, random_fields(), 0);
        send_item(MODE_TICK, make_fields(1'b1, 1'b1, 3'b111, 1'b1, 1'b0, ALL_ONES), 0);
        send_item(MODE_TICK, make_fields(1'b1, 1'b1, 3'b011, 1'b0, 1'b1, ALL_ONES), 0);
        send_item(MODE_TICK, make_fields(1'b0, 1'b0, 3'b000, 1'b1, 1'b1, 16'd0), 0);
        wait_for_reports();
        write_all_regs(16'd0);
        send_item(MODE_FLAPS_DOWN, random_fields(), 0);
        send_item(MODE_BRAKE_EXTEND, random_fields(), 0);
        send_item(MODE_TICK, make_fields(1'b1, 1'b1, 3'b111, 1'b0, 1'b0, 16'd0), 0);
        wait_for_reports();
    endtask

    task automatic test_backpressure();
        int i;
        s_gap_pct   = 0;
        m_stall_pct = 0;
        write_reg(REG_FLAP_SLEW, 16'd700);
        write_reg(REG_BRAKE_SLEW, 16'd900);
        write_reg(REG_GEAR_SLEW, 16'd5000);
        write_reg(REG_MAX_FLAP, 16'd20000);
        write_reg(REG_MAX_SPEED_BRAKE, 16'd30000);
        write_reg(REG_BRAKE_INCREMENT, 16'd3000);
        write_reg(REG_FUEL_THRESHOLD, 16'd40000);
        hold_request <= 300;
        for (i = 0; i < 60; i++)
            send_item(pick_mode(), flight_fields(), 0);
        wait_for_reports();
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned i;
        write_reg(REG_MAX_FLAP, pick_reg(0, 65535));
        write_reg(REG_FLAP_SLEW, pick_reg(1, 3000));
        write_reg(REG_MAX_SPEED_BRAKE, pick_reg(0, 65535));
        write_reg(REG_BRAKE_INCREMENT, pick_reg(1, 12000));
        write_reg(REG_BRAKE_SLEW, pick_reg(1, 3000));
        write_reg(REG_GEAR_SLEW, pick_gear_slew());
        write_reg(REG_FUEL_THRESHOLD, pick_reg(0, 65535));
        case ($urandom_range(0, 3))
            0: begin
                s_gap_pct   = 0;
                m_stall_pct = 0;
            end
            1: begin
                s_gap_pct   = 20;
                m_stall_pct = 20;
            end
            2: begin
                s_gap_pct   = 50;
                m_stall_pct = 10;
            end
            default: begin
                s_gap_pct   = 10;
                m_stall_pct = 50;
            end
        endcase
        for (i = 0; i < count; i++)
            send_item(pick_mode(), flight_fields(), pick_gap(s_gap_pct));
        wait_for_reports();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left    <= hold_request;
            hold_request <= 0;
            m_tready     <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < m_stall_pct) begin
            stall_left <= pick_gap(100) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    always @(posedge aclk) begin
        report_t seen;
        report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen = report_t'(m_tdata);
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %h", $time, m_tdata);
                failures++;
            end else begin
                want = expected_reports.pop_front();
                check_field("flap_target", want.flap_target, seen.flap_target);
                check_field("flap_angle", want.flap_angle, seen.flap_angle);
                check_field("brake_target", want.brake_target, seen.brake_target);
                check_field("brake_position", want.brake_position, seen.brake_position);
                check_field("nose_leg", want.nose_leg, seen.nose_leg);
                check_field("right_leg", want.right_leg, seen.right_leg);
                check_field("left_leg", want.left_leg, seen.left_leg);
                check_field("legs_up", want.legs_up, seen.legs_up);
                check_field("status_bits", want.status_bits, seen.status_bits);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : main
        int phase;
        reset_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_config_extremes();
        test_backpressure();
        for (phase = 0; phase < 8; phase++)
            test_random_traffic(130);
        wait_for_reports();
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
